// ----- sv/hblac_pkg.sv -----
//------------------------------------------------------------------------------
// hblac_pkg
// Shared types and constants of the H-bridge limit and autostop controller.
//------------------------------------------------------------------------------
`default_nettype none

package hblac_pkg;

   // Width of the elapsed-time counter and of the armed run limit.
   localparam int TIME_WIDTH = 16;
   localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

   localparam int DURATION_WIDTH = 16;
   localparam int STEP_WIDTH     = 8;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int CSR_IDX_WIDTH  = 1;

   localparam logic [DURATION_WIDTH-1:0] DURATION_RESET = 16'd2000;
   localparam logic [STEP_WIDTH-1:0]     STEP_RESET     = 8'd10;

   typedef enum logic [1:0] {
      OP_COMMAND = 2'd0,
      OP_TICK    = 2'd1,
      OP_UPPER   = 2'd2,
      OP_LOWER   = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_DURATION = 1'd0,
      CSR_STEP     = 1'd1
   } csr_index_type;

   localparam logic [1:0] DIR_STOP  = 2'd0;
   localparam logic [1:0] DIR_UP    = 2'd1;
   localparam logic [1:0] DIR_DOWN  = 2'd2;
   // Unused direction code; a command with it acts as stop.
   localparam logic [1:0] DIR_SPARE = 2'd3;

   // Pin vector layout: enable, pin A, pin B.
   localparam int PIN_EN = 0;
   localparam int PIN_A  = 1;
   localparam int PIN_B  = 2;

   typedef struct packed {
      logic moving_down;
      logic moving_up;
      logic drive_b;
      logic drive_a;
      logic motor_enable;
   } result_type;

endpackage

`default_nettype wire

// ----- sv/hbridge_limit_autostop_control_top.sv -----
//------------------------------------------------------------------------------
// hbridge_limit_autostop_control_top
// H-bridge controller with two limit switches and a timed autostop.
//------------------------------------------------------------------------------
// Usage:
//   Requests arrive on the req_ stream: req_tuser carries the kind (motor
//   command, timer tick, upper or lower limit update) and req_tdata the
//   direction, autostop flag and switch level. Each request yields exactly
//   one result on the rsp_ stream with the pin levels and moving flags as
//   they stand after that request.
//   The state update and the result are computed combinationally and captured
//   in the result register, so a result appears in the cycle after its request
//   is accepted. One request is accepted per cycle as long as the result
//   register is empty or is being emptied in the same cycle; a stalled
//   receiver holds the result and stalls req_tready until it is taken.
//   The csr_ channel writes the autostop duration (index 0) and the tick
//   step (index 1); it is always ready.
//   A synchronous reset stops the motor, clears the switch levels, the
//   elapsed counter and the run limit, restores the register defaults and
//   empties the result register.
//------------------------------------------------------------------------------
`default_nettype none

module hbridge_limit_autostop_control_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [1:0] direction, [2] autostop, [3] limit_active, [7:4] zero
   input  wire logic [7:0]                           req_tdata,
   // [1:0] op
   input  wire logic [1:0]                           req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [0] motor_enable, [1] drive_a, [2] drive_b, [3] moving_up,
   // [4] moving_down, [7:5] zero
   output logic [7:0]                                rsp_tdata,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [hblac_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  wire logic [hblac_pkg::CSR_DATA_WIDTH-1:0] csr_data
);
   import hblac_pkg::*;

   localparam int WIDE = TIME_WIDTH + DURATION_WIDTH;

   logic [DURATION_WIDTH-1:0] duration_ff;
   logic [STEP_WIDTH-1:0]     step_ff;

   logic                  upward_ff,   upward_in;
   logic                  downward_ff, downward_in;
   logic                  upper_sw_ff, upper_sw_in;
   logic                  lower_sw_ff, lower_sw_in;
   logic [2:0]            pins_ff,     pins_in;
   logic [TIME_WIDTH-1:0] elapsed_ff,  elapsed_in;
   logic [TIME_WIDTH-1:0] limit_ff,    limit_in;

   logic       rsp_valid_ff;
   result_type rsp_data_ff, rsp_data_in;

   logic                  req_accept;
   op_type                op;
   logic [1:0]            direction;
   logic                  autostop;
   logic                  level;
   logic [TIME_WIDTH:0]   tick_sum;
   logic [TIME_WIDTH-1:0] tick_elapsed;
   logic [WIDE-1:0]       duration_wide;
   logic [TIME_WIDTH-1:0] armed_limit;

   assign op        = op_type'(req_tuser);
   assign direction = req_tdata[1:0];
   assign autostop  = req_tdata[2];
   assign level     = req_tdata[3];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign tick_sum      = {1'b0, elapsed_ff} + (TIME_WIDTH+1)'(step_ff);
   assign tick_elapsed  = tick_sum[TIME_WIDTH] ? TIME_MAX : tick_sum[TIME_WIDTH-1:0];
   assign duration_wide = WIDE'(duration_ff);
   assign armed_limit   = (duration_wide > WIDE'(TIME_MAX)) ? TIME_MAX
                                                            : TIME_WIDTH'(duration_wide);

   always_comb begin
      upward_in   = upward_ff;
      downward_in = downward_ff;
      upper_sw_in = upper_sw_ff;
      lower_sw_in = lower_sw_ff;
      pins_in     = pins_ff;
      elapsed_in  = elapsed_ff;
      limit_in    = limit_ff;
      case (op)
         OP_COMMAND: begin
            pins_in[PIN_EN] = 1'b0;
            if (direction == DIR_UP) begin
               if (!upper_sw_ff) begin
                  upward_in   = 1'b1;
                  downward_in = 1'b0;
                  pins_in     = 3'b011;
               end
            end else if (direction == DIR_DOWN) begin
               if (!lower_sw_ff) begin
                  upward_in   = 1'b0;
                  downward_in = 1'b1;
                  pins_in     = 3'b101;
               end
            end else begin
               // Stop and the unused direction code both halt the motor.
               upward_in   = 1'b0;
               downward_in = 1'b0;
               pins_in     = 3'b000;
            end
            if (autostop) begin
               elapsed_in = '0;
               limit_in   = armed_limit;
            end else begin
               limit_in = '0;
            end
         end
         OP_TICK: begin
            elapsed_in = tick_elapsed;
            if (limit_ff != '0 && tick_elapsed >= limit_ff) begin
               upward_in   = 1'b0;
               downward_in = 1'b0;
               pins_in     = 3'b000;
               limit_in    = '0;
               elapsed_in  = '0;
            end
         end
         OP_UPPER: begin
            upper_sw_in = level;
            if (level && !downward_ff) begin
               upward_in   = 1'b0;
               downward_in = 1'b0;
               pins_in     = 3'b000;
            end
         end
         OP_LOWER: begin
            lower_sw_in = level;
            if (level && !upward_ff) begin
               upward_in   = 1'b0;
               downward_in = 1'b0;
               pins_in     = 3'b000;
            end
         end
         default: begin
            pins_in = pins_ff;
         end
      endcase
      rsp_data_in.motor_enable = pins_in[PIN_EN];
      rsp_data_in.drive_a      = pins_in[PIN_A];
      rsp_data_in.drive_b      = pins_in[PIN_B];
      rsp_data_in.moving_up    = upward_in;
      rsp_data_in.moving_down  = downward_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duration_ff  <= DURATION_RESET;
         step_ff      <= STEP_RESET;
         upward_ff    <= 1'b0;
         downward_ff  <= 1'b0;
         upper_sw_ff  <= 1'b0;
         lower_sw_ff  <= 1'b0;
         pins_ff      <= 3'b000;
         elapsed_ff   <= '0;
         limit_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_DURATION: duration_ff <= csr_data[DURATION_WIDTH-1:0];
               CSR_STEP:     step_ff     <= csr_data[STEP_WIDTH-1:0];
               default:      step_ff     <= step_ff;
            endcase
         end
         if (req_accept) begin
            upward_ff    <= upward_in;
            downward_ff  <= downward_in;
            upper_sw_ff  <= upper_sw_in;
            lower_sw_ff  <= lower_sw_in;
            pins_ff      <= pins_in;
            elapsed_ff   <= elapsed_in;
            limit_ff     <= limit_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};

   // The bridge is never enabled with both or neither direction pin high.
   assert property (@(posedge clock) disable iff (reset)
      pins_ff[PIN_EN] |-> $onehot(pins_ff[PIN_B:PIN_A]))
      else $error("enable high without exactly one direction pin");

   assert property (@(posedge clock) disable iff (reset)
      !(upward_ff && downward_ff))
      else $error("moving up and down at once");

   // An enabled pin A matches the upward flag that set it.
   assert property (@(posedge clock) disable iff (reset)
      (pins_ff[PIN_EN] && pins_ff[PIN_A]) |-> upward_ff)
      else $error("pin A enabled without the upward flag");

   // An armed limit is cleared as soon as the elapsed count reaches it.
   assert property (@(posedge clock) disable iff (reset)
      (limit_ff != '0) |-> (elapsed_ff < limit_ff))
      else $error("armed run limit reached but not disarmed");

endmodule

`default_nettype wire
